### rtl/hdr_tone_mapper_core_assert.svh
// Assertion macros for the tone mapper core.
// Each macro needs clk and rst_n in scope.
`ifndef HDR_TONE_MAPPER_CORE_ASSERT_SVH
`define HDR_TONE_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication.
`define HDRTM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdrtm assertion failed");

// Next-cycle implication.
`define HDRTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdrtm assertion failed");

`endif

### rtl/hdrtm_pkg.sv
package hdrtm_pkg;

    // Fraction bits of the log2 / exp2 approximations
    localparam int CURVE_TABLE_BITS = 10;

    localparam int RAD_W    = 24;
    localparam int T_W      = 17;
    localparam int Q16_BITS = 16;
    localparam logic [T_W-1:0] Q16_ONE = 17'h10000;
    localparam int ACC_W    = 21;
    localparam int WHOLE_W  = 17;

    // ACES coefficients, Q16
    localparam logic [17:0] ACES_A = 18'd164495;
    localparam logic [37:0] ACES_B = 38'd1966 << 16;
    localparam logic [17:0] ACES_C = 18'd159252;
    localparam logic [37:0] ACES_D = 38'd38666 << 16;
    localparam logic [42:0] ACES_E = 43'd9175 << 16;
    localparam int DEN_W = 43;

    // log2(e) in Q16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // 2^-(2^-(j+1)) in Q20
    localparam logic [19:0] HALF_POWERS [12] = '{
        20'd741455, 20'd881744, 20'd961548, 20'd1004120, 20'd1026107, 20'd1037281,
        20'd1042913, 20'd1045741, 20'd1047157, 20'd1047866, 20'd1048221, 20'd1048399
    };

    // Stage counts
    localparam int EXP2_LAT   = CURVE_TABLE_BITS + 1;
    localparam int ACES_LAT   = 4 + Q16_BITS;
    localparam int CURVE_DLY  = ACES_LAT - 1 - EXP2_LAT;
    localparam int LOG_N_W    = CURVE_TABLE_BITS + 5;
    localparam int GDIV_W     = LOG_N_W + 12;
    localparam int GAM_LAT    = 1 + CURVE_TABLE_BITS + 1 + GDIV_W + EXP2_LAT;
    localparam int LANE_LAT   = 2 + ACES_LAT + 1 + GAM_LAT + 1;

    typedef enum logic [1:0] {
        CFG_EXPOSURE  = 2'd0,
        CFG_CURVE     = 2'd1,
        CFG_GAMMA_EN  = 2'd2,
        CFG_GAMMA_VAL = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] exposure_gain;
        logic        curve_mode;
        logic        gamma_enable;
        logic [15:0] gamma_value;
    } cfg_t;

endpackage

### rtl/hdr_tone_mapper_core.sv
// The two restoring dividers, one bit per stage, set the depth of the pipeline
// from input word to output word.
// Throughput: one pixel per cycle; the whole pipeline holds while the output stalls.
// Reset clears the valid bits and loads the registers: exposure 1.0, ACES curve,
// gamma off, gamma 2.2. The datapath itself is not reset.
`include "hdr_tone_mapper_core_assert.svh"

module hdr_tone_mapper_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // red_radiance [23:0], green_radiance [47:24], blue_radiance [71:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_byte [7:0], green_byte [15:8], blue_byte [23:16]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int LAT = hdrtm_pkg::LANE_LAT;

    hdrtm_pkg::cfg_t cfg_reg;
    logic [LAT-1:0]  vld_reg;
    logic            ce;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exposure_gain <= 16'd256;
            cfg_reg.curve_mode    <= 1'b1;
            cfg_reg.gamma_enable  <= 1'b0;
            cfg_reg.gamma_value   <= 16'd9011;
        end
        else if (cfg_we)
        begin
            unique case (hdrtm_pkg::cfg_index_t'(cfg_addr))
                hdrtm_pkg::CFG_EXPOSURE:  cfg_reg.exposure_gain <= cfg_wdata;
                hdrtm_pkg::CFG_CURVE:     cfg_reg.curve_mode    <= cfg_wdata[0];
                hdrtm_pkg::CFG_GAMMA_EN:  cfg_reg.gamma_enable  <= cfg_wdata[0];
                hdrtm_pkg::CFG_GAMMA_VAL: cfg_reg.gamma_value   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance whenever the output word is free or being taken
    assign ce       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    hdrtm_lane u_red
    (
        .clk      (clk),
        .ce       (ce),
        .cfg      (cfg_reg),
        .radiance (s_tdata[23:0]),
        .pix_byte (m_tdata[7:0])
    );

    hdrtm_lane u_green
    (
        .clk      (clk),
        .ce       (ce),
        .cfg      (cfg_reg),
        .radiance (s_tdata[47:24]),
        .pix_byte (m_tdata[15:8])
    );

    hdrtm_lane u_blue
    (
        .clk      (clk),
        .ce       (ce),
        .cfg      (cfg_reg),
        .radiance (s_tdata[71:48]),
        .pix_byte (m_tdata[23:16])
    );

    // Accepted word enters the first stage
    `HDRTM_ASSERT_NEXT(a_enter, s_tvalid && s_tready, vld_reg[0])
    // Stalled pipeline keeps every valid bit
    `HDRTM_ASSERT_NEXT(a_hold, !ce, $stable(vld_reg))
    // Input is refused only while a finished word waits
    `HDRTM_ASSERT_NOW(a_ready, !s_tready, m_tvalid && !m_tready)

endmodule

### rtl/hdrtm_exp2.sv
module hdrtm_exp2
(
    input  logic                                  clk,
    input  logic                                  ce,
    input  logic [hdrtm_pkg::WHOLE_W-1:0]         whole,
    input  logic [hdrtm_pkg::CURVE_TABLE_BITS-1:0] frac,
    output logic [hdrtm_pkg::T_W-1:0]             res
);

    localparam int CTB = hdrtm_pkg::CURVE_TABLE_BITS;
    localparam int AW  = hdrtm_pkg::ACC_W;
    localparam int WW  = hdrtm_pkg::WHOLE_W;

    logic [AW-1:0]  acc_reg   [CTB];
    logic [AW-1:0]  acc_next  [CTB];
    logic [WW-1:0]  whole_reg [CTB];
    logic [CTB-1:0] frac_reg  [CTB];
    logic [hdrtm_pkg::T_W-1:0] res_reg;
    logic [hdrtm_pkg::T_W-1:0] res_next;
    logic [4:0]     sh;
    logic [AW-1:0]  shifted;

    // One multiply per fraction bit, MSB first
    for (genvar j = 0; j < CTB; j++)
    begin : g_step
        logic [AW-1:0]  acc_in;
        logic [WW-1:0]  whole_in;
        logic [CTB-1:0] frac_in;
        logic [AW+19:0] prod;

        if (j == 0)
        begin : g_first
            assign acc_in   = AW'(1) << 20;
            assign whole_in = whole;
            assign frac_in  = frac;
        end
        else
        begin : g_rest
            assign acc_in   = acc_reg[j-1];
            assign whole_in = whole_reg[j-1];
            assign frac_in  = frac_reg[j-1];
        end

        assign prod        = acc_in * hdrtm_pkg::HALF_POWERS[j];
        assign acc_next[j] = frac_in[CTB-1-j] ? prod[AW+19:20] : acc_in;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                acc_reg[j]   <= acc_next[j];
                whole_reg[j] <= whole_in;
                frac_reg[j]  <= frac_in;
            end
        end
    end

    // Apply the integer part as a right shift
    always_comb
    begin
        sh      = whole_reg[CTB-1][4:0] + 5'd4;
        shifted = acc_reg[CTB-1] >> sh;
        if (whole_reg[CTB-1] >= WW'(21))
            res_next = '0;
        else
            res_next = shifted[hdrtm_pkg::T_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### rtl/hdrtm_aces.sv
module hdrtm_aces
(
    input  logic                          clk,
    input  logic                          ce,
    input  logic [hdrtm_pkg::RAD_W-1:0]   x,
    output logic [hdrtm_pkg::T_W-1:0]     t
);

    localparam int DW = hdrtm_pkg::DEN_W;
    localparam int QB = hdrtm_pkg::Q16_BITS;

    logic [20:0] xa;
    logic [20:0] xa_c_reg, xa_d_reg;
    logic [37:0] pa_reg, pc_reg, sa_reg, sc_reg;
    logic [40:0] sa_lo_reg, sc_lo_reg;
    logic [38:0] sa_hi_reg, sc_hi_reg;
    logic [58:0] num_full, den_full;
    logic [DW-1:0] num_reg, den_reg;
    logic [DW-1:0] r_reg   [QB];
    logic [DW-1:0] dv_reg  [QB];
    logic [QB-1:0] q_reg   [QB];
    logic          sat_reg [QB];

    // Clamp input to 16.0
    assign xa = (x > 24'h100000) ? 21'h100000 : x[20:0];

    // Linear terms, bias terms, split products, numerator / denominator
    always_comb
    begin
        num_full = ({20'd0, sa_hi_reg} << 20) + {18'd0, sa_lo_reg};
        den_full = ({20'd0, sc_hi_reg} << 20) + {18'd0, sc_lo_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pa_reg    <= 38'(hdrtm_pkg::ACES_A * xa);
            pc_reg    <= 38'(hdrtm_pkg::ACES_C * xa);
            xa_c_reg  <= xa;
            sa_reg    <= pa_reg + hdrtm_pkg::ACES_B;
            sc_reg    <= pc_reg + hdrtm_pkg::ACES_D;
            xa_d_reg  <= xa_c_reg;
            sa_lo_reg <= sa_reg[19:0] * xa_d_reg;
            sa_hi_reg <= sa_reg[37:20] * xa_d_reg;
            sc_lo_reg <= sc_reg[19:0] * xa_d_reg;
            sc_hi_reg <= sc_reg[37:20] * xa_d_reg;
            num_reg   <= num_full[DW+15:16];
            den_reg   <= den_full[DW+15:16] + hdrtm_pkg::ACES_E;
        end
    end

    // Restoring divide, one quotient bit per stage
    for (genvar i = 0; i < QB; i++)
    begin : g_div
        logic [DW-1:0] r_in, dv_in;
        logic [QB-1:0] q_in;
        logic          sat_in;
        logic [DW:0]   rs;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign r_in   = num_reg;
            assign dv_in  = den_reg;
            assign q_in   = '0;
            assign sat_in = (num_reg >= den_reg);
        end
        else
        begin : g_rest
            assign r_in   = r_reg[i-1];
            assign dv_in  = dv_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign sat_in = sat_reg[i-1];
        end

        assign rs   = {r_in, 1'b0};
        assign ge   = (rs >= {1'b0, dv_in});
        assign diff = rs - {1'b0, dv_in};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                r_reg[i]   <= ge ? diff[DW-1:0] : rs[DW-1:0];
                dv_reg[i]  <= dv_in;
                q_reg[i]   <= {q_in[QB-2:0], ge};
                sat_reg[i] <= sat_in;
            end
        end
    end

    assign t = sat_reg[QB-1] ? hdrtm_pkg::Q16_ONE : {1'b0, q_reg[QB-1]};

endmodule

### rtl/hdrtm_gamma.sv
module hdrtm_gamma
(
    input  logic                       clk,
    input  logic                       ce,
    input  logic [hdrtm_pkg::T_W-1:0]  t_in,
    input  logic [15:0]                gamma_value,
    output logic [hdrtm_pkg::T_W-1:0]  t_out
);

    localparam int CTB = hdrtm_pkg::CURVE_TABLE_BITS;
    localparam int NW  = hdrtm_pkg::LOG_N_W;
    localparam int DVW = hdrtm_pkg::GDIV_W;

    logic [3:0]     p_enc;
    logic [20:0]    m_first;
    logic [20:0]    m0_reg;
    logic [3:0]     p0_reg;
    logic [20:0]    m_reg  [CTB];
    logic [CTB-1:0] lf_reg [CTB];
    logic [3:0]     p_reg  [CTB];
    logic [NW-1:0]  n_next;
    logic [NW-1:0]  n_reg;
    logic [15:0]    g;
    logic [15:0]    r_reg   [DVW];
    logic [DVW-1:0] dvd_reg [DVW];
    logic [DVW-1:0] q_reg   [DVW];
    logic [DVW-1:0] mag;

    // Leading one and normalized mantissa in Q20
    always_comb
    begin
        p_enc = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (t_in[i])
                p_enc = 4'(i);
        end
    end

    assign m_first = 21'({5'd0, t_in[15:0]} << (5'd20 - {1'b0, p_enc}));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m0_reg <= m_first;
            p0_reg <= p_enc;
        end
    end

    // Log2 fraction by repeated squaring
    for (genvar i = 0; i < CTB; i++)
    begin : g_sq
        logic [20:0]    m_in;
        logic [CTB-1:0] lf_in;
        logic [3:0]     p_in;
        logic [41:0]    sq;
        logic [21:0]    s;

        if (i == 0)
        begin : g_first
            assign m_in  = m0_reg;
            assign lf_in = '0;
            assign p_in  = p0_reg;
        end
        else
        begin : g_rest
            assign m_in  = m_reg[i-1];
            assign lf_in = lf_reg[i-1];
            assign p_in  = p_reg[i-1];
        end

        assign sq = m_in * m_in;
        assign s  = sq[41:20];

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                m_reg[i]  <= s[21] ? s[21:1] : s[20:0];
                lf_reg[i] <= {lf_in[CTB-2:0], s[21]};
                p_reg[i]  <= p_in;
            end
        end
    end

    // Magnitude of log2, scaled by 2^CTB
    assign n_next = {5'd16 - {1'b0, p_reg[CTB-1]}, {CTB{1'b0}}} - {5'd0, lf_reg[CTB-1]};

    always_ff @(posedge clk)
    begin
        if (ce)
            n_reg <= n_next;
    end

    assign g = (gamma_value == 16'd0) ? 16'd1 : gamma_value;

    // Divide by gamma, one quotient bit per stage
    for (genvar i = 0; i < DVW; i++)
    begin : g_div
        logic [15:0]    r_in;
        logic [DVW-1:0] dvd_in, q_in;
        logic [16:0]    rs, diff;
        logic           ge;

        if (i == 0)
        begin : g_first
            assign r_in   = '0;
            assign dvd_in = {n_reg, 12'd0};
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign r_in   = r_reg[i-1];
            assign dvd_in = dvd_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        assign rs   = {r_in, dvd_in[DVW-1]};
        assign ge   = (rs >= {1'b0, g});
        assign diff = rs - {1'b0, g};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                r_reg[i]   <= ge ? diff[15:0] : rs[15:0];
                dvd_reg[i] <= {dvd_in[DVW-2:0], 1'b0};
                q_reg[i]   <= {q_in[DVW-2:0], ge};
            end
        end
    end

    assign mag = q_reg[DVW-1];

    hdrtm_exp2 u_exp2
    (
        .clk   (clk),
        .ce    (ce),
        .whole (mag[DVW-1:CTB]),
        .frac  (mag[CTB-1:0]),
        .res   (t_out)
    );

endmodule

### rtl/hdrtm_lane.sv
module hdrtm_lane
(
    input  logic                        clk,
    input  logic                        ce,
    input  hdrtm_pkg::cfg_t             cfg,
    input  logic [hdrtm_pkg::RAD_W-1:0] radiance,
    output logic [7:0]                  pix_byte
);

    localparam int CTB = hdrtm_pkg::CURVE_TABLE_BITS;
    localparam int TW  = hdrtm_pkg::T_W;

    logic [39:0]   prod_reg;
    logic [23:0]   x_reg;
    logic [23:0]   x_next;
    logic [40:0]   uprod_reg;
    logic [TW-1:0] aces_t, exp_res, gam_t;
    logic [TW-1:0] exp_dly_reg [hdrtm_pkg::CURVE_DLY];
    logic [TW-1:0] t_reg, t_next;
    logic [TW-1:0] t_dly_reg [hdrtm_pkg::GAM_LAT];
    logic [TW-1:0] tf;
    logic [TW-1:0] t_late;
    logic [24:0]   scaled;
    logic [7:0]    byte_reg;

    // Exposure, saturated to 24 bits
    assign x_next = (prod_reg[39:32] != 8'd0) ? 24'hFFFFFF : prod_reg[31:8];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            prod_reg  <= radiance * cfg.exposure_gain;
            x_reg     <= x_next;
            uprod_reg <= x_reg * hdrtm_pkg::LOG2E_Q16;
        end
    end

    hdrtm_aces u_aces
    (
        .clk (clk),
        .ce  (ce),
        .x   (x_reg),
        .t   (aces_t)
    );

    hdrtm_exp2 u_curve_exp2
    (
        .clk   (clk),
        .ce    (ce),
        .whole ({8'd0, uprod_reg[40:32]}),
        .frac  (uprod_reg[31:32-CTB]),
        .res   (exp_res)
    );

    // Align the exponential curve with the ACES divider
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            exp_dly_reg[0] <= exp_res;
            for (int i = 1; i < hdrtm_pkg::CURVE_DLY; i++)
                exp_dly_reg[i] <= exp_dly_reg[i-1];
        end
    end

    assign t_next = cfg.curve_mode ? aces_t
                  : hdrtm_pkg::Q16_ONE - exp_dly_reg[hdrtm_pkg::CURVE_DLY-1];

    always_ff @(posedge clk)
    begin
        if (ce)
            t_reg <= t_next;
    end

    hdrtm_gamma u_gamma
    (
        .clk         (clk),
        .ce          (ce),
        .t_in        (t_reg),
        .gamma_value (cfg.gamma_value),
        .t_out       (gam_t)
    );

    // Carry the ungamma'd value past the gamma unit
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t_dly_reg[0] <= t_reg;
            for (int i = 1; i < hdrtm_pkg::GAM_LAT; i++)
                t_dly_reg[i] <= t_dly_reg[i-1];
        end
    end

    // Zero and one pass through gamma unchanged
    assign t_late = t_dly_reg[hdrtm_pkg::GAM_LAT-1];
    assign tf     = (cfg.gamma_enable && t_late != '0 && !t_late[TW-1]) ? gam_t : t_late;
    assign scaled = tf * 8'd255;

    always_ff @(posedge clk)
    begin
        if (ce)
            byte_reg <= scaled[23:16];
    end

    assign pix_byte = byte_reg;

endmodule

### sim/hdr_tone_mapper_core_tb.sv
`timescale 1ns / 1ps

module hdr_tone_mapper_core_tb;

    localparam int TBITS = 10;
    localparam int LAT_WAIT = 2 * hdrtm_pkg::LANE_LAT + 20;
    localparam int CYCLE_LIMIT = 400000;

    // Working copy of the block's registers
    logic [15:0] exp_gain;
    logic        mode_aces;
    logic        gam_on;
    logic [15:0] gam_val;

    logic [19:0] halves [12] = '{
        20'd741455, 20'd881744, 20'd961548, 20'd1004120, 20'd1026107, 20'd1037281,
        20'd1042913, 20'd1045741, 20'd1047157, 20'd1047866, 20'd1048221, 20'd1048399
    };

    int errors = 0;

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [63:0] pow2_neg(input logic [63:0] whole, input logic [63:0] frac);
        logic [63:0] acc;
        acc = 64'd1 << 20;
        for (int j = 0; j < TBITS; j++)
            if (frac[TBITS-1-j])
                acc = (acc * halves[j]) >> 20;
        if (whole >= 21)
            return 64'd0;
        return acc >> (whole + 4);
    endfunction

    function automatic logic [63:0] raise_inv_gamma(input logic [63:0] t);
        logic [63:0] m, lf, n, mag, g;
        int p;
        if (t == 0 || t >= 64'h10000)
            return t;
        p = 15;
        while (t[p] == 1'b0)
            p--;
        m = t << (20 - p);
        lf = 0;
        for (int i = 0; i < TBITS; i++)
        begin
            m = (m * m) >> 20;
            lf = lf << 1;
            if (m >= (64'd2 << 20))
            begin
                lf[0] = 1'b1;
                m = m >> 1;
            end
        end
        n = (64'(16 - p) << TBITS) - lf;
        g = (gam_val == 0) ? 64'd1 : 64'(gam_val);
        mag = (n << 12) / g;
        return pow2_neg(mag >> TBITS, mag & ((64'd1 << TBITS) - 1));
    endfunction

    function automatic logic [7:0] map_to_byte(input logic [23:0] rad);
        logic [63:0] e, x, t, num, den, u;
        e = (64'(rad) * exp_gain) >> 8;
        if (e > 64'hFFFFFF)
            e = 64'hFFFFFF;
        x = e;
        if (mode_aces)
        begin
            if (x > (64'd1 << 20))
                x = 64'd1 << 20;
            num = ((64'd164495 * x + (64'd1966 << 16)) * x) >> 16;
            den = (((64'd159252 * x + (64'd38666 << 16)) * x) >> 16) + (64'd9175 << 16);
            t = (num >= den) ? 64'h10000 : (num << 16) / den;
        end
        else
        begin
            u = (x * 64'd94548) >> 16;
            t = 64'h10000 - pow2_neg(u >> 16, (u & 64'hFFFF) >> (16 - TBITS));
        end
        if (t > 64'h10000)
            t = 64'h10000;
        if (gam_on)
            t = raise_inv_gamma(t);
        return 8'((t * 255) >> 16);
    endfunction

    class pixel_scoreboard;
        logic [23:0] pending [$];

        function void note_pixel(input logic [71:0] px);
            pending.push_back({map_to_byte(px[71:48]), map_to_byte(px[47:24]),
                               map_to_byte(px[23:0])});
        endfunction

        task check_pixel(input logic [23:0] got);
            logic [23:0] want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("unexpected output word %h at %0t", got, $realtime);
            end
            else
            begin
                want = pending.pop_front();
                if (got[7:0] != want[7:0])
                    report("red_byte", got[7:0], want[7:0]);
                if (got[15:8] != want[15:8])
                    report("green_byte", got[15:8], want[15:8]);
                if (got[23:16] != want[23:16])
                    report("blue_byte", got[23:16], want[23:16]);
            end
        endtask
    endclass

    pixel_scoreboard board = new();

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    hdr_tone_mapper_core dut (.*);

    // Run controls for the input and output sides, and run counters
    bit  src_idle = 1;
    bit  sink_idle = 1;
    int  hold_off = 0;
    longint cycles = 0;
    int  pixels_sent = 0;
    int  words_seen = 0;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Limit the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check each output word and draw the next ready value
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_pixel(m_tdata);
            words_seen++;
        end
        if (hold_off > 0)
        begin
            hold_off--;
            m_tready <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 9) == 0)
            hold_off = $urandom_range(1, 8);
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(input hdrtm_pkg::cfg_index_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            hdrtm_pkg::CFG_EXPOSURE:  exp_gain = val;
            hdrtm_pkg::CFG_CURVE:     mode_aces = val[0];
            hdrtm_pkg::CFG_GAMMA_EN:  gam_on = val[0];
            hdrtm_pkg::CFG_GAMMA_VAL: gam_val = val;
        endcase
    endtask

    // Offer one pixel, with optional idle gaps, until accepted
    task automatic send_pixel(input logic [71:0] px);
        int gap;
        if (src_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_channel();
        case ($urandom_range(0, 4))
            0: return 24'($urandom_range(0, 255));
            1: return 24'($urandom_range(0, 24'h3FFFF));
            2: return 24'($urandom_range(0, 24'hFFFFF));
            3: return 24'hFFFFFF - 24'($urandom_range(0, 15));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel({rand_channel(), rand_channel(), rand_channel()});
    endtask

    initial
    begin
        static logic [15:0] gains [6] = '{16'd256, 16'd0, 16'd65535, 16'd1, 16'd64, 16'd4096};
        static logic [15:0] gvals [6] = '{16'd9011, 16'd1, 16'd65535, 16'd0, 16'd4096, 16'd2048};
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_we = 0;
        cfg_addr = hdrtm_pkg::CFG_EXPOSURE;
        cfg_wdata = '0;
        exp_gain = 16'd256;
        mode_aces = 1'b1;
        gam_on = 1'b0;
        gam_val = 16'd9011;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes at reset settings, then with each curve and gamma
        for (int m = 0; m < 4; m++)
        begin
            if (m > 0)
            begin
                write_reg(hdrtm_pkg::CFG_CURVE, 16'(m[0]));
                write_reg(hdrtm_pkg::CFG_GAMMA_EN, 16'(m[1]));
            end
            send_pixel({24'h000000, 24'hFFFFFF, 24'h010000});
            send_pixel({24'h000001, 24'hAAAAAA, 24'h555555});
            send_pixel({24'h100000, 24'h0000FF, 24'h080000});
            send_pixel({24'hFFFFFF, 24'h000000, 24'h008000});
            send_pixel({24'h004000, 24'h200000, 24'h000010});
            drain();
        end

        // Random phases over a sweep of register settings
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(hdrtm_pkg::CFG_EXPOSURE, gains[ph % 6]);
            write_reg(hdrtm_pkg::CFG_CURVE, 16'($urandom_range(0, 1)) | 16'hFFFE);
            write_reg(hdrtm_pkg::CFG_GAMMA_EN, 16'(ph % 3 != 0));
            write_reg(hdrtm_pkg::CFG_GAMMA_VAL, gvals[(ph * 5) % 6]);
            if (ph == 10)
            begin
                src_idle = 0;
                sink_idle = 0;
            end
            if (ph == 4)
            begin
                // Hold the output side off while the input keeps offering
                hold_off = 3 * hdrtm_pkg::LANE_LAT;
                random_pixels(2 * hdrtm_pkg::LANE_LAT);
            end
            else
                random_pixels(135);
            drain();
        end

        $display("covered %0d pixels and %0d output words over both curves,", pixels_sent,
                 words_seen);
        $display("gamma on and off, and exposure and gamma values at their extremes");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
